/* src/gbci_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gbci_pkg;

    localparam int ANGLE_BITS_DEF     = 48;
    localparam int BIAS_FRAC_BITS_DEF = 8;

    localparam int RATE_W          = 16;
    localparam int SCALE_W         = 32;
    localparam int COUNT_W         = 16;
    localparam int SUM_W           = 32;
    localparam int ANGLE_OUT_W     = 48;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int HEADING_W       = 25;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;
    localparam int NUM_AXES        = 3;
    localparam int AXIS_W          = 2;

    // 360 degrees in Q9.16
    localparam logic [HEADING_W-1:0] HEADING_FULL = 25'd23592960;

    localparam logic [SCALE_W-1:0] SCALE_DT_RST      = 32'd262288;
    localparam logic [COUNT_W-1:0] CALIB_SAMPLES_RST = 16'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES = 1'd1;

    localparam logic [AXIS_W-1:0] AXIS_ROLL = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_YAW  = 2'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_ZERO   = 2'd1,
        OP_RECAL  = 2'd2
    } op_t;

    typedef struct packed {
        logic              load_in;
        logic              calib_acc;
        logic              clear_calib;
        logic              zero_angles;
        logic              bias_zero;
        logic              bias_start;
        logic              bias_write;
        logic              calib_finish;
        logic              diff_load;
        logic              mul_load;
        logic              step_load;
        logic              angle_load;
        logic              head_start;
        logic              head_write;
        logic              head_zero;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic read_ok;
        logic calib_active;
        logic calib_end;
        logic valid_zero;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

/* src/gbci_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbci_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 25
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient,
    output logic [DVS_W-1:0]      remainder
);
    // restoring division, two quotient bits per cycle
    localparam int ITER  = DVD_W / 2;
    localparam int CNT_W = ($clog2(ITER) > 0) ? $clog2(ITER) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   r1;
    logic [DVS_W:0]   r1s;
    logic [DVS_W:0]   r2;
    logic [DVS_W:0]   r2s;
    logic             q1;
    logic             q2;

    always_comb
    begin
        r1  = {rem_reg, dvd_reg[DVD_W-1]};
        q1  = (r1 >= {1'b0, dvs_reg});
        r1s = q1 ? (r1 - {1'b0, dvs_reg}) : r1;
        r2  = {r1s[DVS_W-1:0], dvd_reg[DVD_W-2]};
        q2  = (r2 >= {1'b0, dvs_reg});
        r2s = q2 ? (r2 - {1'b0, dvs_reg}) : r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ITER - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-3:0], q1, q2};
            rem_reg <= r2s[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* src/gbci_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbci_dp #(
    parameter int ANGLE_BITS     = 48,
    parameter int BIAS_FRAC_BITS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [gbci_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gbci_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [1:0]                           opcode,
    input  wire logic                                 read_ok,
    input  wire logic signed [gbci_pkg::RATE_W-1:0]   rate_x,
    input  wire logic signed [gbci_pkg::RATE_W-1:0]   rate_y,
    input  wire logic signed [gbci_pkg::RATE_W-1:0]   rate_z,
    input  wire gbci_pkg::cmd_t                       cmd,
    output gbci_pkg::status_t                         status,
    output logic signed [gbci_pkg::ANGLE_OUT_W-1:0]   roll_angle,
    output logic signed [gbci_pkg::ANGLE_OUT_W-1:0]   pitch_angle,
    output logic signed [gbci_pkg::ANGLE_OUT_W-1:0]   yaw_angle,
    output logic [gbci_pkg::HEADING_W-1:0]            heading,
    output logic                                      calibrating
);
    import gbci_pkg::*;

    localparam int BIAS_W  = RATE_W + 1 + BIAS_FRAC_BITS;
    localparam int DIFF_W  = RATE_W + 2 + BIAS_FRAC_BITS;
    localparam int HALF_W  = SCALE_W / 2;
    localparam int PART_W  = DIFF_W + HALF_W + 1;
    localparam int PROD_W  = DIFF_W + SCALE_W + 1;
    localparam int STEP_SH = BIAS_FRAC_BITS + ANGLE_FRAC_BITS;
    localparam int STEP_W  = PROD_W - STEP_SH;
    localparam int ACC_W   = ((ANGLE_BITS > STEP_W) ? ANGLE_BITS : STEP_W) + 2;
    localparam int EXT_W   = (ANGLE_BITS > ANGLE_OUT_W) ? ANGLE_BITS : ANGLE_OUT_W;
    localparam int DVD_RAW = (SUM_W + BIAS_FRAC_BITS > ANGLE_BITS) ?
                             (SUM_W + BIAS_FRAC_BITS) : ANGLE_BITS;
    localparam int DVD_W   = DVD_RAW + (DVD_RAW % 2);
    localparam int DVS_W   = HEADING_W;

    localparam logic signed [ACC_W-1:0] ANG_MAX =
        {{(ACC_W - ANGLE_BITS + 1){1'b0}}, {(ANGLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ANG_MIN = ~ANG_MAX;

    // configuration
    logic [SCALE_W-1:0]            scale_dt_reg;
    logic [COUNT_W-1:0]            calib_samples_reg;

    // item latched at transfer
    op_t                           op_reg;
    logic                          ok_reg;
    logic signed [RATE_W-1:0]      raw_reg [NUM_AXES];

    // block state
    logic                          calib_active_reg;
    logic [COUNT_W-1:0]            attempt_reg;
    logic [COUNT_W-1:0]            valid_reg;
    logic signed [SUM_W-1:0]       sum_reg [NUM_AXES];
    logic signed [BIAS_W-1:0]      bias_reg [NUM_AXES];
    logic signed [ANGLE_BITS-1:0]  angle_reg [NUM_AXES];
    logic [HEADING_W-1:0]          heading_reg;

    // integration pipeline
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [PART_W-1:0]      lo_reg;
    logic signed [PART_W-1:0]      hi_reg;
    logic signed [STEP_W-1:0]      step_reg;

    // result register
    logic [ANGLE_OUT_W-1:0]        out_angle_reg [NUM_AXES];
    logic [HEADING_W-1:0]          out_heading_reg;
    logic                          out_calib_reg;

    logic [COUNT_W-1:0]            attempt_inc;
    logic signed [DIFF_W-1:0]      diff_val;
    logic signed [PART_W-1:0]      lo_val;
    logic signed [PART_W-1:0]      hi_val;
    logic signed [PROD_W-1:0]      prod_val;
    logic signed [STEP_W-1:0]      step_val;
    logic signed [ACC_W-1:0]       acc_a;
    logic signed [ACC_W-1:0]       acc_d;
    logic signed [ACC_W-1:0]       acc_s;
    logic signed [ANGLE_BITS-1:0]  angle_sat;
    logic [ANGLE_BITS-1:0]         yaw_mag;
    logic [SUM_W-1:0]              sum_mag;
    logic signed [BIAS_W-1:0]      quo_s;
    logic signed [BIAS_W-1:0]      bias_val;
    logic [HEADING_W-1:0]          heading_val;
    logic signed [EXT_W-1:0]       ext_angle [NUM_AXES];

    logic                          div_start;
    logic [DVD_W-1:0]              div_dividend;
    logic [DVS_W-1:0]              div_divisor;
    logic                          div_done;
    logic [DVD_W-1:0]              div_quo;
    logic [DVS_W-1:0]              div_rem;

    assign attempt_inc = attempt_reg + 1'b1;

    always_comb
    begin
        status.op           = op_reg;
        status.read_ok      = ok_reg;
        status.calib_active = calib_active_reg;
        status.calib_end    = (attempt_inc >= calib_samples_reg);
        status.valid_zero   = (valid_reg == '0);
        status.div_done     = div_done;
    end

    // integration arithmetic, one stage per cycle
    always_comb
    begin
        diff_val = (DIFF_W'(raw_reg[cmd.axis]) <<< BIAS_FRAC_BITS)
                   - DIFF_W'(bias_reg[cmd.axis]);
        lo_val   = diff_reg * $signed({1'b0, scale_dt_reg[HALF_W-1:0]});
        hi_val   = diff_reg * $signed({1'b0, scale_dt_reg[SCALE_W-1:HALF_W]});
        prod_val = PROD_W'(lo_reg) + (PROD_W'(hi_reg) <<< HALF_W);
        // arithmetic shift floors toward minus infinity
        step_val = STEP_W'(prod_val >>> STEP_SH);

        acc_a = ACC_W'(angle_reg[cmd.axis]);
        acc_d = (cmd.axis == AXIS_YAW) ? -ACC_W'(step_reg) : ACC_W'(step_reg);
        acc_s = acc_a + acc_d;
        if (acc_s > ANG_MAX)
        begin
            angle_sat = ANGLE_BITS'(ANG_MAX);
        end
        else if (acc_s < ANG_MIN)
        begin
            angle_sat = ANGLE_BITS'(ANG_MIN);
        end
        else
        begin
            angle_sat = ANGLE_BITS'(acc_s);
        end
    end

    // shared divider: bias = sum * 2^F / count, heading = |yaw| mod 360
    always_comb
    begin
        yaw_mag = angle_reg[AXIS_YAW][ANGLE_BITS-1] ?
                  ANGLE_BITS'(-angle_reg[AXIS_YAW]) : ANGLE_BITS'(angle_reg[AXIS_YAW]);
        sum_mag = sum_reg[cmd.axis][SUM_W-1] ?
                  SUM_W'(-sum_reg[cmd.axis]) : SUM_W'(sum_reg[cmd.axis]);
        div_start    = cmd.bias_start | cmd.head_start;
        div_dividend = cmd.head_start ? DVD_W'(yaw_mag)
                                      : (DVD_W'(sum_mag) << BIAS_FRAC_BITS);
        div_divisor  = cmd.head_start ? HEADING_FULL : DVS_W'(valid_reg);

        quo_s    = $signed(div_quo[BIAS_W-1:0]);
        bias_val = sum_reg[cmd.axis][SUM_W-1] ? -quo_s : quo_s;

        // floor modulo: negative yaw folds back from the top
        if (angle_reg[AXIS_YAW][ANGLE_BITS-1] && (div_rem != '0))
        begin
            heading_val = HEADING_FULL - div_rem;
        end
        else
        begin
            heading_val = div_rem;
        end

        for (int i = 0; i < NUM_AXES; i++)
        begin
            ext_angle[i] = EXT_W'(angle_reg[i]);
        end
    end

    gbci_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_dt_reg      <= SCALE_DT_RST;
            calib_samples_reg <= CALIB_SAMPLES_RST;
            calib_active_reg  <= 1'b1;
            attempt_reg       <= '0;
            valid_reg         <= '0;
            heading_reg       <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sum_reg[i]   <= '0;
                bias_reg[i]  <= '0;
                angle_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCALE_DT:      scale_dt_reg      <= cfg_data[SCALE_W-1:0];
                    CFG_CALIB_SAMPLES: calib_samples_reg <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.clear_calib)
            begin
                calib_active_reg <= 1'b1;
                attempt_reg      <= '0;
                valid_reg        <= '0;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end

            if (cmd.calib_acc)
            begin
                attempt_reg <= attempt_inc;
                if (ok_reg)
                begin
                    valid_reg <= valid_reg + 1'b1;
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        sum_reg[i] <= sum_reg[i] + SUM_W'(raw_reg[i]);
                    end
                end
            end

            if (cmd.bias_zero)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    bias_reg[i] <= '0;
                end
            end

            if (cmd.bias_write)
            begin
                bias_reg[cmd.axis] <= bias_val;
            end

            if (cmd.calib_finish)
            begin
                calib_active_reg <= 1'b0;
            end

            if (cmd.zero_angles)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    angle_reg[i] <= '0;
                end
            end

            if (cmd.angle_load)
            begin
                angle_reg[cmd.axis] <= angle_sat;
            end

            if (cmd.head_zero)
            begin
                heading_reg <= '0;
            end
            else if (cmd.head_write)
            begin
                heading_reg <= heading_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= op_t'(opcode);
            ok_reg     <= read_ok;
            raw_reg[0] <= rate_x;
            raw_reg[1] <= rate_y;
            raw_reg[2] <= rate_z;
        end
        if (cmd.diff_load)
        begin
            diff_reg <= diff_val;
        end
        if (cmd.mul_load)
        begin
            lo_reg <= lo_val;
            hi_reg <= hi_val;
        end
        if (cmd.step_load)
        begin
            step_reg <= step_val;
        end
        if (cmd.load_out)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                out_angle_reg[i] <= ext_angle[i][ANGLE_OUT_W-1:0];
            end
            out_heading_reg <= heading_reg;
            out_calib_reg   <= calib_active_reg;
        end
    end

    assign roll_angle  = out_angle_reg[0];
    assign pitch_angle = out_angle_reg[1];
    assign yaw_angle   = out_angle_reg[2];
    assign heading     = out_heading_reg;
    assign calibrating = out_calib_reg;

endmodule

`default_nettype wire

/* src/gbci_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbci_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output gbci_pkg::cmd_t         cmd,
    input  wire gbci_pkg::status_t status
);
    import gbci_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_BIAS_START,
        S_BIAS_WAIT,
        S_INT_DIFF,
        S_INT_MUL,
        S_INT_STEP,
        S_INT_SAT,
        S_HEAD_START,
        S_HEAD_WAIT,
        S_OUT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AXIS_W-1:0] axis_reg;
    logic [AXIS_W-1:0] axis_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                axis_next  = AXIS_ROLL;
                state_next = S_OUT;
                case (status.op)
                    OP_ZERO:
                    begin
                        cmd.zero_angles = 1'b1;
                        cmd.head_zero   = 1'b1;
                    end
                    OP_RECAL:
                    begin
                        cmd.clear_calib = 1'b1;
                    end
                    OP_SAMPLE:
                    begin
                        if (status.calib_active)
                        begin
                            cmd.calib_acc = 1'b1;
                            if (status.calib_end)
                            begin
                                state_next = S_BIAS_START;
                            end
                        end
                        else if (status.read_ok)
                        begin
                            state_next = S_INT_DIFF;
                        end
                    end
                    default: ;
                endcase
            end

            S_BIAS_START:
            begin
                if (status.valid_zero)
                begin
                    cmd.bias_zero    = 1'b1;
                    cmd.calib_finish = 1'b1;
                    state_next       = S_OUT;
                end
                else
                begin
                    cmd.bias_start = 1'b1;
                    state_next     = S_BIAS_WAIT;
                end
            end

            S_BIAS_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.bias_write = 1'b1;
                    if (axis_reg == AXIS_YAW)
                    begin
                        cmd.calib_finish = 1'b1;
                        state_next       = S_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_BIAS_START;
                    end
                end
            end

            S_INT_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = S_INT_MUL;
            end

            S_INT_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_INT_STEP;
            end

            S_INT_STEP:
            begin
                cmd.step_load = 1'b1;
                state_next    = S_INT_SAT;
            end

            S_INT_SAT:
            begin
                cmd.angle_load = 1'b1;
                if (axis_reg == AXIS_YAW)
                begin
                    state_next = S_HEAD_START;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_INT_DIFF;
                end
            end

            S_HEAD_START:
            begin
                cmd.head_start = 1'b1;
                state_next     = S_HEAD_WAIT;
            end

            S_HEAD_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.head_write = 1'b1;
                    state_next     = S_OUT;
                end
            end

            S_OUT:
            begin
                // result register frees up when empty or being taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = cmd.load_out | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_ROLL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/gyro_bias_calibrate_and_integrate_top.sv */
// Commands, invalid reads and calibration samples pass through S_EXEC and S_OUT to the result;
//   an integrating sample steps through S_INT_DIFF, S_INT_MUL, S_INT_STEP and S_INT_SAT for
//   each of the three axes, then the heading modulo on the shared 2-bit-per-cycle divider.
// The sample that ends calibration also runs the bias divides, one per axis, on that divider.
// Throughput: one item at a time; the next transfer is taken the cycle after the result
//   is registered. Reset (async, active low) starts calibration, zeroes angles and biases.
`timescale 1ns / 1ps
`default_nettype none

module gyro_bias_calibrate_and_integrate_top #(
    parameter int ANGLE_BITS     = gbci_pkg::ANGLE_BITS_DEF,
    parameter int BIAS_FRAC_BITS = gbci_pkg::BIAS_FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [gbci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gbci_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         opcode,
    input  wire logic                               read_ok,
    input  wire logic signed [gbci_pkg::RATE_W-1:0] rate_x,
    input  wire logic signed [gbci_pkg::RATE_W-1:0] rate_y,
    input  wire logic signed [gbci_pkg::RATE_W-1:0] rate_z,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [gbci_pkg::ANGLE_OUT_W-1:0] roll_angle,
    output logic signed [gbci_pkg::ANGLE_OUT_W-1:0] pitch_angle,
    output logic signed [gbci_pkg::ANGLE_OUT_W-1:0] yaw_angle,
    output logic [gbci_pkg::HEADING_W-1:0]          heading,
    output logic                                    calibrating
);
    import gbci_pkg::*;

    cmd_t    cmd;
    status_t status;

    gbci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    gbci_dp #(
        .ANGLE_BITS     (ANGLE_BITS),
        .BIAS_FRAC_BITS (BIAS_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .read_ok     (read_ok),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .cmd         (cmd),
        .status      (status),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .heading     (heading),
        .calibrating (calibrating)
    );

endmodule

`default_nettype wire

/* src/gbci_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbci_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [gbci_pkg::ANGLE_OUT_W-1:0]   roll_angle,
    input wire logic [gbci_pkg::ANGLE_OUT_W-1:0]   yaw_angle,
    input wire logic [gbci_pkg::HEADING_W-1:0]     heading
);
    import gbci_pkg::*;

    // one item in flight: a transfer closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // no result can appear the cycle right after a transfer
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading < HEADING_FULL))
        else $error("heading outside [0,360)");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(roll_angle) && $stable(yaw_angle) && $stable(heading))
        else $error("stalled result changed");

endmodule

bind gyro_bias_calibrate_and_integrate_top gbci_checker u_gbci_checker (.*);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

localparam int STEP_SHIFT = gbci_pkg::BIAS_FRAC_BITS_DEF + gbci_pkg::ANGLE_FRAC_BITS;
localparam longint ANGLE_HI = (64'sd1 <<< (gbci_pkg::ANGLE_BITS_DEF - 1)) - 64'sd1;
localparam longint ANGLE_LO = -ANGLE_HI - 64'sd1;

typedef struct packed {
    logic [gbci_pkg::ANGLE_OUT_W-1:0] roll;
    logic [gbci_pkg::ANGLE_OUT_W-1:0] pitch;
    logic [gbci_pkg::ANGLE_OUT_W-1:0] yaw;
    logic [gbci_pkg::HEADING_W-1:0]   heading;
    logic                             calibrating;
} attitude_t;

class attitude_tracker;
    bit [gbci_pkg::SCALE_W-1:0] scale_dt;
    bit [gbci_pkg::COUNT_W-1:0] calib_len;
    bit                         cal_active;
    bit [gbci_pkg::COUNT_W-1:0] attempts;
    bit [gbci_pkg::COUNT_W-1:0] valid_n;
    longint                     rate_sum[gbci_pkg::NUM_AXES];
    longint                     bias[gbci_pkg::NUM_AXES];
    longint                     angle[gbci_pkg::NUM_AXES];
    attitude_t                  pending_attitudes[$];
    int                         mismatches;
    int                         checked;

    function void restart_calibration();
        cal_active = 1'b1;
        attempts   = '0;
        valid_n    = '0;
        foreach (rate_sum[i]) rate_sum[i] = 0;
    endfunction

    function void reset_state();
        scale_dt  = gbci_pkg::SCALE_DT_RST;
        calib_len = gbci_pkg::CALIB_SAMPLES_RST;
        restart_calibration();
        foreach (angle[i])
        begin
            bias[i]  = 0;
            angle[i] = 0;
        end
    endfunction

    function void write_reg(logic [gbci_pkg::CFG_IDX_W-1:0] idx,
                            logic [gbci_pkg::CFG_DATA_W-1:0] data);
        if (idx == gbci_pkg::CFG_SCALE_DT)
            scale_dt = data;
        else
            calib_len = data[gbci_pkg::COUNT_W-1:0];
    endfunction

    function void predict_item(logic [1:0] op, logic ok,
                               logic signed [gbci_pkg::RATE_W-1:0] rx,
                               logic signed [gbci_pkg::RATE_W-1:0] ry,
                               logic signed [gbci_pkg::RATE_W-1:0] rz);
        longint    raw[gbci_pkg::NUM_AXES];
        longint    diff;
        longint    stepv;
        longint    head;
        longint    full_turn;
        attitude_t want;
        int        i;
        raw[0]    = rx;
        raw[1]    = ry;
        raw[2]    = rz;
        full_turn = longint'(gbci_pkg::HEADING_FULL);
        case (op)
            gbci_pkg::OP_ZERO:
                foreach (angle[k]) angle[k] = 0;
            gbci_pkg::OP_RECAL:
                restart_calibration();
            gbci_pkg::OP_SAMPLE:
            begin
                if (cal_active)
                begin
                    attempts++;
                    if (ok)
                    begin
                        for (i = 0; i < gbci_pkg::NUM_AXES; i++) rate_sum[i] += raw[i];
                        valid_n++;
                    end
                    if (attempts >= calib_len)
                    begin
                        for (i = 0; i < gbci_pkg::NUM_AXES; i++)
                            bias[i] = (valid_n != 0)
                                ? (rate_sum[i] * (64'sd1 <<< gbci_pkg::BIAS_FRAC_BITS_DEF))
                                  / longint'(valid_n)
                                : 0;
                        cal_active = 1'b0;
                    end
                end
                else if (ok)
                begin
                    for (i = 0; i < gbci_pkg::NUM_AXES; i++)
                    begin
                        diff  = raw[i] * (64'sd1 <<< gbci_pkg::BIAS_FRAC_BITS_DEF) - bias[i];
                        // arithmetic shift of the signed product floors toward minus infinity
                        stepv = (diff * longint'({32'd0, scale_dt})) >>> STEP_SHIFT;
                        if (i == gbci_pkg::AXIS_YAW)
                            stepv = -stepv;
                        angle[i] = angle[i] + stepv;
                        if (angle[i] > ANGLE_HI)
                            angle[i] = ANGLE_HI;
                        else if (angle[i] < ANGLE_LO)
                            angle[i] = ANGLE_LO;
                    end
                end
            end
            default: ;
        endcase
        head = angle[gbci_pkg::AXIS_YAW] % full_turn;
        if (head < 0)
            head += full_turn;
        want.roll        = angle[0][gbci_pkg::ANGLE_OUT_W-1:0];
        want.pitch       = angle[1][gbci_pkg::ANGLE_OUT_W-1:0];
        want.yaw         = angle[2][gbci_pkg::ANGLE_OUT_W-1:0];
        want.heading     = head[gbci_pkg::HEADING_W-1:0];
        want.calibrating = cal_active;
        pending_attitudes.push_back(want);
    endfunction

    task report(string what);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    task check_attitude(attitude_t got);
        attitude_t want;
        if (pending_attitudes.size() == 0)
        begin
            report($sformatf("result transfer with nothing expected (roll %h)", got.roll));
            return;
        end
        want = pending_attitudes.pop_front();
        checked++;
        compare_field("roll_angle", got.roll, want.roll);
        compare_field("pitch_angle", got.pitch, want.pitch);
        compare_field("yaw_angle", got.yaw, want.yaw);
        compare_field("heading", got.heading, want.heading);
        compare_field("calibrating", got.calibrating, want.calibrating);
    endtask
endclass

module tb;
    import gbci_pkg::*;

    localparam logic [1:0]              OP_UNUSED  = 2'd3;
    localparam logic signed [RATE_W-1:0] RATE_MAX  = 16'sh7FFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN  = 16'sh8000;
    localparam int                      IDLE_LIMIT = 2000;
    localparam int                      END_WAIT   = 120;
    localparam int                      SAT_ITEMS  = 32800;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [1:0]               opcode    = OP_SAMPLE;
    logic                     read_ok   = 1'b0;
    logic signed [RATE_W-1:0] rate_x    = '0;
    logic signed [RATE_W-1:0] rate_y    = '0;
    logic signed [RATE_W-1:0] rate_z    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [ANGLE_OUT_W-1:0] roll_angle;
    logic signed [ANGLE_OUT_W-1:0] pitch_angle;
    logic signed [ANGLE_OUT_W-1:0] yaw_angle;
    logic [HEADING_W-1:0]     heading;
    logic                     calibrating;

    bit  stall_en   = 1'b0;
    bit  stall_on   = 1'b0;
    int  stall_left = 0;
    bit  gaps_en    = 1'b0;
    int  burst_left = 0;
    int  idle_count = 0;
    int  items_sent = 0;
    int  settings_run = 0;
    int  center[NUM_AXES];

    attitude_tracker tracker;

    gyro_bias_calibrate_and_integrate_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .read_ok     (read_ok),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .heading     (heading),
        .calibrating (calibrating)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            tracker.predict_item(opcode, read_ok, rate_x, rate_y, rate_z);
            items_sent++;
        end
        if (out_valid && !out_stall)
            tracker.check_attitude('{roll_angle, pitch_angle, yaw_angle, heading, calibrating});
    end

    // receiver: alternating stall and free runs of random length
    always @(negedge clk)
    begin
        if (!stall_en)
        begin
            stall_on  = 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_on   = !stall_on;
                stall_left = stall_on ? $urandom_range(1, 16) : $urandom_range(1, 24);
            end
            stall_left--;
            out_stall <= stall_on;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_count <= 0;
        else if (idle_count >= IDLE_LIMIT)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

    task automatic send_item(input logic [1:0] op, input logic ok,
                             input logic signed [RATE_W-1:0] rx,
                             input logic signed [RATE_W-1:0] ry,
                             input logic signed [RATE_W-1:0] rz);
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        read_ok  <= ok;
        rate_x   <= rx;
        rate_y   <= ry;
        rate_z   <= rz;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic pause_input(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_attitudes.size() != 0) @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    function automatic logic signed [RATE_W-1:0] pick_rate(input int mid);
        int v;
        int k;
        case ($urandom_range(0, 19))
            0: v = 32767;
            1: v = -32768;
            2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            default:
            begin
                k = $urandom_range(0, 11);
                v = mid + int'($urandom_range(0, 2 << k)) - (1 << k);
            end
        endcase
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[RATE_W-1:0];
    endfunction

    task automatic random_item();
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = OP_RECAL;
        else if (r < 6)
            op = OP_ZERO;
        else if (r < 8)
            op = OP_UNUSED;
        else
            op = OP_SAMPLE;
        send_item(op, $urandom_range(0, 99) < 88,
                  pick_rate(center[0]), pick_rate(center[1]), pick_rate(center[2]));
    endtask

    task automatic run_traffic(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                if (gaps_en)
                    pause_input($urandom_range(1, 15));
                if ($urandom_range(0, 49) == 0)
                    wait_results();
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            random_item();
        end
    endtask

    task automatic start_setting(input logic [CFG_DATA_W-1:0] scale,
                                 input logic [CFG_DATA_W-1:0] samples, input bit idle_on);
        int i;
        wait_results();
        write_reg(CFG_SCALE_DT, scale);
        write_reg(CFG_CALIB_SAMPLES, samples);
        @(posedge clk);
        stall_en = idle_on;
        gaps_en  = idle_on;
        for (i = 0; i < NUM_AXES; i++) center[i] = int'($urandom_range(0, 6000)) - 3000;
        settings_run++;
    endtask

    initial
    begin
        int p;
        tracker = new();
        tracker.reset_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // calibration on reset values of both registers
        send_item(OP_UNUSED, 1'b1, 16'sh1234, -16'sd77, 16'sd3);
        send_item(OP_SAMPLE, 1'b0, 16'sd500, 16'sd500, 16'sd500);
        send_item(OP_SAMPLE, 1'b1, RATE_MAX, RATE_MIN, 16'sd0);
        send_item(OP_ZERO, 1'b1, 16'sd0, 16'sd0, 16'sd0);
        wait_results();
        write_reg(CFG_CALIB_SAMPLES, 32'd65535);
        send_item(OP_SAMPLE, 1'b1, -16'sd1, 16'sd1, RATE_MIN);
        // length now below the attempt count: the next sample closes calibration
        wait_results();
        write_reg(CFG_CALIB_SAMPLES, 32'd1);
        send_item(OP_SAMPLE, 1'b1, 16'sd100, -16'sd100, 16'sd7);
        send_item(OP_SAMPLE, 1'b1, RATE_MAX, RATE_MIN, RATE_MAX);
        send_item(OP_SAMPLE, 1'b1, RATE_MIN, RATE_MAX, RATE_MIN);
        send_item(OP_SAMPLE, 1'b0, RATE_MAX, RATE_MAX, RATE_MAX);
        send_item(OP_SAMPLE, 1'b1, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_UNUSED, 1'b0, RATE_MIN, RATE_MIN, RATE_MIN);
        // zero length, no valid read: biases fall back to zero
        wait_results();
        write_reg(CFG_CALIB_SAMPLES, 32'd0);
        send_item(OP_RECAL, 1'b1, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_SAMPLE, 1'b0, 16'sd1000, 16'sd1000, 16'sd1000);
        send_item(OP_SAMPLE, 1'b1, 16'sd1, -16'sd1, -16'sd1);
        wait_results();
        write_reg(CFG_SCALE_DT, 32'd0);
        send_item(OP_SAMPLE, 1'b1, RATE_MAX, RATE_MIN, RATE_MAX);
        // tiny scale: positive steps vanish, negative ones floor to -1
        wait_results();
        write_reg(CFG_SCALE_DT, 32'd1);
        send_item(OP_SAMPLE, 1'b1, 16'sd1, -16'sd1, -16'sd1);
        wait_results();
        write_reg(CFG_SCALE_DT, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, 1'b1, RATE_MAX, RATE_MIN, RATE_MIN);
        send_item(OP_ZERO, 1'b0, 16'sd0, 16'sd0, 16'sd0);

        for (p = 0; p < 7; p++)
        begin
            case (p)
                0: start_setting(SCALE_DT_RST, $urandom_range(2, 16), 1'b1);
                1: start_setting(32'd0, $urandom_range(1, 8), 1'b1);
                2: start_setting(32'hFFFF_FFFF, 32'd1, 1'b0);
                3: start_setting($urandom, 32'd0, 1'b1);
                4: start_setting($urandom_range(1, 4095), $urandom_range(1, 24), 1'b1);
                5: start_setting($urandom, 32'd65535, 1'b1);
                default: start_setting($urandom, {$urandom_range(0, 65535), 16'd3}, 1'b1);
            endcase
            if (p == 5)
                send_item(OP_RECAL, 1'b1, 16'sd0, 16'sd0, 16'sd0);
            run_traffic(95);
        end

        // drive roll to the upper limit, pitch and yaw to the lower one
        start_setting(32'hFFFF_FFFF, 32'd2, 1'b0);
        send_item(OP_RECAL, 1'b0, 16'sd0, 16'sd0, 16'sd0);
        repeat (2) send_item(OP_SAMPLE, 1'b1, RATE_MIN, RATE_MAX, RATE_MIN);
        send_item(OP_ZERO, 1'b0, 16'sd0, 16'sd0, 16'sd0);
        repeat (SAT_ITEMS) send_item(OP_SAMPLE, 1'b1, RATE_MAX, RATE_MIN, RATE_MAX);

        start_setting(SCALE_DT_RST, 32'd4, 1'b1);
        send_item(OP_ZERO, 1'b1, 16'sd0, 16'sd0, 16'sd0);
        run_traffic(40);

        wait_results();
        repeat (END_WAIT) @(posedge clk);
        $display("Run covered %0d input transfers and %0d checked results over %0d settings,",
                 items_sent, tracker.checked, settings_run + 1);
        $display("with directed corner items and a full angle saturation sweep.");
        if (tracker.mismatches == 0 && tracker.pending_attitudes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* filelist.f */
src/gbci_pkg.sv
src/gbci_div.sv
src/gbci_dp.sv
src/gbci_ctrl.sv
src/gyro_bias_calibrate_and_integrate_top.sv
src/gbci_checker.sv
verif/tb.sv
